// File: rtl/pst_pkg.sv
// Package for the parenthesis reorder checker: character codes, command word
// type, back-end state encoding and default sizes.
// No dependencies.
package pst_pkg;

	// Default sizes
	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned OUT_DEPTH_DEF   = 63;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// Character codes
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_FLUSH = 8'h23;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Classified command
	typedef enum logic [1:0] {
		OP_OPEN,
		OP_CLOSE,
		OP_FLUSH,
		OP_CHAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_VERD,
		ST_DRAIN
	} bk_state_t;

	// Map a character to its command (bang is filtered before this)
	function automatic op_t classify(input logic [7:0] c);
		op_t op;
		case (c)
			CH_OPEN:  op = OP_OPEN;
			CH_CLOSE: op = OP_CLOSE;
			CH_FLUSH: op = OP_FLUSH;
			default:  op = OP_CHAR;
		endcase
		return op;
	endfunction

endpackage

// File: rtl/pst_if.sv
// Channel interfaces for the parenthesis reorder checker: the character input
// channel and the result channel, both valid/ready.
// No dependencies.
interface pst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface pst_out_if;
	logic       valid;
	logic       ready;
	logic       is_verdict;
	logic       verdict_ok;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output is_verdict, output verdict_ok,
		output char_out, output last, input ready);
	modport sink   (input valid, input is_verdict, input verdict_ok,
		input char_out, input last, output ready);
endinterface

// File: rtl/pst_front.sv
// Front end: accepts input words, drops bangs and registers the classified
// command for the queue. Depends on pst_pkg and pst_if.
module pst_front (
	input  logic          clk,
	input  logic          arst_n,
	pst_in_if.sink        in_word,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output pst_pkg::cmd_t cmd
);
	import pst_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;
	logic accept;
	logic is_bang;

	assign in_word.ready = !v_s1 || cmd_ready;
	assign accept        = in_word.valid && in_word.ready;
	assign is_bang       = (in_word.char_in == CH_BANG);

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= !is_bang;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept && !is_bang) begin
			cmd_s1.op <= classify(in_word.char_in);
			cmd_s1.ch <= in_word.char_in;
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

// File: rtl/pst_queue.sv
// Short command queue between front and back ends.
// Depends on pst_pkg.
module pst_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pst_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pst_pkg::cmd_t pop_cmd
);
	import pst_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/pst_back.sv
// Back end: executes commands against the character stack and output buffer,
// emits verdict and buffered characters through an output register.
// Depends on pst_pkg and pst_if.
module pst_back #(
	parameter int unsigned STACK_DEPTH = pst_pkg::STACK_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH   = pst_pkg::OUT_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pst_pkg::cmd_t cmd,
	pst_out_if.source     out_word
);
	import pst_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int OAW  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

	bk_state_t state_q, state_d;
	logic [SP_W-1:0]  sp_q, sp_d, sp_m1;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d, idx_p1;
	logic             err_q, err_d;
	logic             st_full, ob_full, slot_free;

	// Stack memory ports
	logic [7:0]    stack_mem [STACK_DEPTH];
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [7:0]    st_wdata, st_rdata_q;

	// Output buffer memory ports
	logic [7:0]     obuf_mem [OUT_DEPTH];
	logic           ob_we, ob_re;
	logic [OAW-1:0] ob_waddr, ob_raddr;
	logic [7:0]     ob_wdata, ob_rdata_q;

	// Output register
	logic       ov_q, o_verd_q, o_ok_q, o_last_q;
	logic [7:0] o_ch_q;
	logic       ld, ld_verd, ld_ok, ld_last;
	logic [7:0] ld_ch;

	assign sp_m1     = sp_q - 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign st_full   = (sp_q == SP_W'(STACK_DEPTH));
	assign ob_full   = (cnt_q == CNT_W'(OUT_DEPTH));
	assign slot_free = !ov_q || out_word.ready;

	// Sequencer: next state, memory controls and result load
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		err_d     = err_q;
		cmd_ready = 1'b0;
		st_we     = 1'b0;
		st_waddr  = sp_q[AW-1:0];
		st_wdata  = cmd.ch;
		st_re     = 1'b0;
		st_raddr  = sp_m1[AW-1:0];
		ob_we     = 1'b0;
		ob_waddr  = cnt_q[OAW-1:0];
		ob_wdata  = cmd.ch;
		ob_re     = 1'b0;
		ob_raddr  = '0;
		ld        = 1'b0;
		ld_verd   = 1'b0;
		ld_ok     = 1'b0;
		ld_ch     = 8'h00;
		ld_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd.op)
						OP_FLUSH: begin
							state_d = ST_VERD;
						end
						OP_OPEN: begin
							if (!err_q) begin
								if (st_full) begin
									err_d = 1'b1;
								end else begin
									st_we = 1'b1;
									sp_d  = sp_q + 1'b1;
								end
							end
						end
						OP_CHAR: begin
							if (!err_q) begin
								if (sp_q == '0) begin
									// outside parentheses: straight to buffer
									if (ob_full) begin
										err_d = 1'b1;
									end else begin
										ob_we = 1'b1;
										cnt_d = cnt_q + 1'b1;
									end
								end else if (st_full) begin
									err_d = 1'b1;
								end else begin
									st_we = 1'b1;
									sp_d  = sp_q + 1'b1;
								end
							end
						end
						OP_CLOSE: begin
							if (!err_q) begin
								if (sp_q == '0) begin
									err_d = 1'b1;
								end else begin
									st_re   = 1'b1;
									sp_d    = sp_m1;
									state_d = ST_POP;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_POP: begin
				// popped entry is in st_rdata_q
				if (st_rdata_q == CH_OPEN) begin
					state_d = ST_IDLE;
				end else begin
					if (st_rdata_q != CH_ZERO) begin
						ob_wdata = st_rdata_q;
						if (ob_full) begin
							err_d = 1'b1;
						end else begin
							ob_we = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
					end
					if (sp_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						st_re = 1'b1;
						sp_d  = sp_m1;
					end
				end
			end
			ST_VERD: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_verd = 1'b1;
					ld_ok   = (sp_q == '0) && !err_q;
					ld_last = (cnt_q == '0);
					if (cnt_q == '0) begin
						sp_d    = '0;
						err_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						ob_re   = 1'b1;
						ob_raddr = '0;
						idx_d   = '0;
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_ch   = ob_rdata_q;
					ld_last = (idx_p1 == cnt_q);
					if (idx_p1 == cnt_q) begin
						sp_d    = '0;
						cnt_d   = '0;
						err_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						ob_re    = 1'b1;
						ob_raddr = idx_p1[OAW-1:0];
						idx_d    = idx_p1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			err_q   <= err_d;
		end
	end

	// Stack memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			stack_mem[st_waddr] <= st_wdata;
		end
		if (st_re) begin
			st_rdata_q <= stack_mem[st_raddr];
		end
	end

	// Output buffer memory
	always_ff @(posedge clk) begin
		if (ob_we) begin
			obuf_mem[ob_waddr] <= ob_wdata;
		end
		if (ob_re) begin
			ob_rdata_q <= obuf_mem[ob_raddr];
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ld) begin
			ov_q <= 1'b1;
		end else if (out_word.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (ld) begin
			o_verd_q <= ld_verd;
			o_ok_q   <= ld_ok;
			o_ch_q   <= ld_ch;
			o_last_q <= ld_last;
		end
	end

	assign out_word.valid      = ov_q;
	assign out_word.is_verdict = o_verd_q;
	assign out_word.verdict_ok = o_ok_q;
	assign out_word.char_out   = o_ch_q;
	assign out_word.last       = o_last_q;

endmodule

// File: rtl/paren_stack_reorder_checker.sv
// A word passes the front register and a queue slot before it reaches the back end;
// push and append are done in ST_IDLE, ')' pops k stack entries through ST_POP, and '#'
// loads the verdict and then the n buffered characters, and waits while the result side stalls.
// Throughput is set by the back-end sequencer: 1 word per cycle in ST_IDLE, held by pops and drains.
// Reset clears pointers, counts, error flag and queue; the memories are not cleared.
// Top level of the parenthesis reorder checker: front, queue and back end.
// Depends on pst_pkg, pst_if, pst_front, pst_queue and pst_back.
module paren_stack_reorder_checker #(
	parameter int unsigned STACK_DEPTH = pst_pkg::STACK_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH   = pst_pkg::OUT_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pst_in_if.sink     in_word,
	pst_out_if.source  out_word
);
	import pst_pkg::*;

	logic fq_valid, fq_ready;
	cmd_t fq_cmd;
	logic qb_valid, qb_ready;
	cmd_t qb_cmd;

	pst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	pst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	pst_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.OUT_DEPTH   (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_word  (out_word)
	);

endmodule

// File: rtl/pst_checker.sv
// Port-level checks for the parenthesis reorder checker, bound to the top.
// Depends on the top level's result channel only.
module pst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_verdict,
	input logic       verdict_ok,
	input logic [7:0] char_out,
	input logic       last
);

	// a verdict opens every run; after a word with last the next is a verdict
	logic expect_verd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_verd_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			expect_verd_q <= last;
		end
	end

	// stalled result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(is_verdict) && $stable(verdict_ok)
			&& $stable(char_out) && $stable(last))
		else $error("result payload changed while stalled");

	// run framing: verdict first, then characters up to last
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_verdict == expect_verd_q))
		else $error("verdict and character words out of order");

	// verdict carries no character; character words carry no ok
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_verdict && char_out == 8'h00) || (!is_verdict && !verdict_ok))
		else $error("result fields inconsistent with word kind");

endmodule

bind paren_stack_reorder_checker pst_checker u_pst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_word.valid),
	.out_ready  (out_word.ready),
	.is_verdict (out_word.is_verdict),
	.verdict_ok (out_word.verdict_ok),
	.char_out   (out_word.char_out),
	.last       (out_word.last)
);
